[rtl/core/rsenc_pkg.sv]
// ----------------------------------------------------------------------------
// rsenc_pkg
// GF(256) arithmetic and shared types for the Reed-Solomon encoder
// ----------------------------------------------------------------------------
package rsenc_pkg;

  localparam int MAX_PARITY_DEF = 32;
  localparam int PARITY_RESET   = 16;
  localparam int CFG_W          = 6;
  localparam int SYM_W          = 8;

  // low byte of field polynomial 0x11d
  localparam logic [SYM_W-1:0] GF_POLY_LOW = 8'h1d;

  typedef struct packed {
    logic clear;
    logic build;
    logic step;
    logic shift;
  } cell_ctrl_t;

  function automatic logic [SYM_W-1:0] gf_xtime(input logic [SYM_W-1:0] a);
    gf_xtime = {a[SYM_W-2:0], 1'b0} ^ (a[SYM_W-1] ? GF_POLY_LOW : '0);
  endfunction

  function automatic logic [SYM_W-1:0] gf_mul(input logic [SYM_W-1:0] a,
                                              input logic [SYM_W-1:0] b);
    logic [SYM_W-1:0] x;
    logic [SYM_W-1:0] r;
    x = a;
    r = '0;
    for (int k = 0; k < SYM_W; k++) begin
      if (b[k]) begin
        r = r ^ x;
      end
      x = gf_xtime(x);
    end
    gf_mul = r;
  endfunction

endpackage

[rtl/core/rsenc_cell.sv]
// ----------------------------------------------------------------------------
// rsenc_cell
// One tap of the encoder chain: one remainder byte and one generator coefficient
// ----------------------------------------------------------------------------
module rsenc_cell (
  input  logic                         clk,
  input  rsenc_pkg::cell_ctrl_t        ctrl,
  input  logic [rsenc_pkg::SYM_W-1:0]  fb,
  input  logic [rsenc_pkg::SYM_W-1:0]  root,
  input  logic [rsenc_pkg::SYM_W-1:0]  rem_in,
  input  logic [rsenc_pkg::SYM_W-1:0]  coef_in,
  output logic [rsenc_pkg::SYM_W-1:0]  rem_out,
  output logic [rsenc_pkg::SYM_W-1:0]  coef_out
);

  logic [rsenc_pkg::SYM_W-1:0] rem;
  logic [rsenc_pkg::SYM_W-1:0] coef;

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      rem  <= '0;
      coef <= '0;
    end else begin
      // generator build: multiply by (x + root)
      if (ctrl.build) begin
        coef <= coef ^ rsenc_pkg::gf_mul(coef_in, root);
      end
      if (ctrl.step) begin
        rem <= rem_in ^ rsenc_pkg::gf_mul(coef, fb);
      end else if (ctrl.shift) begin
        rem <= rem_in;
      end
    end
  end

  assign rem_out  = rem;
  assign coef_out = coef;

endmodule

[rtl/core/rs_systematic_encoder_gf256.sv]
// ----------------------------------------------------------------------------
// rs_systematic_encoder_gf256
// Systematic Reed-Solomon encoder over GF(256), field polynomial 0x11d
// ----------------------------------------------------------------------------
// an accepted data item is registered straight into the output register
// throughput: one data item per cycle unless stalled, set by the lfsr cell chain
// after the last data item the p parity items leave one per cycle unless stalled
// input stalled in parity run and in generator rebuild after reset or cfg write
// reset is synchronous: parity count 16, remainder cleared, output empty
// ----------------------------------------------------------------------------
module rs_systematic_encoder_gf256 #(
  parameter int MAX_PARITY = rsenc_pkg::MAX_PARITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [rsenc_pkg::CFG_W-1:0]   cfg_wdata,  // parity_count
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [rsenc_pkg::SYM_W-1:0]   s_tdata,    // data_byte
  input  logic                          s_tlast,    // last_data
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [rsenc_pkg::SYM_W-1:0]   m_tdata,    // code_byte
  output logic                          m_tuser,    // is_parity
  output logic                          m_tlast     // end_of_codeword
);

  localparam int CW = $clog2(MAX_PARITY + 1);
  localparam int RESET_P = (rsenc_pkg::PARITY_RESET > MAX_PARITY) ?
                           MAX_PARITY : rsenc_pkg::PARITY_RESET;
  localparam logic [rsenc_pkg::CFG_W-1:0] MAX_CFG = rsenc_pkg::CFG_W'(MAX_PARITY);

  logic [CW-1:0]                 par_cnt;
  logic [CW-1:0]                 build_cnt;
  logic [CW-1:0]                 emit_cnt;
  logic [rsenc_pkg::SYM_W-1:0]   root;
  logic [rsenc_pkg::CFG_W-1:0]   cfg_clamped;
  logic                          out_ready;
  logic                          in_fire;
  logic                          emit_fire;
  logic                          building;
  logic [rsenc_pkg::SYM_W-1:0]   fb;
  rsenc_pkg::cell_ctrl_t         ctrl;

  logic [rsenc_pkg::SYM_W-1:0]   rem_chain  [MAX_PARITY+1];
  logic [rsenc_pkg::SYM_W-1:0]   coef_chain [MAX_PARITY+1];

  always_comb begin
    priority if (cfg_wdata == '0) begin
      cfg_clamped = rsenc_pkg::CFG_W'(1);
    end else if (cfg_wdata > MAX_CFG) begin
      cfg_clamped = MAX_CFG;
    end else begin
      cfg_clamped = cfg_wdata;
    end
  end

  assign building  = (build_cnt != '0);
  assign out_ready = !m_tvalid || m_tready;
  assign s_tready  = !building && (emit_cnt == '0) && out_ready;
  assign in_fire   = s_tvalid && s_tready;
  assign emit_fire = (emit_cnt != '0) && out_ready;
  assign fb        = s_tdata ^ rem_chain[0];

  always_comb begin
    ctrl.clear = rst || cfg_wen;
    ctrl.build = building;
    ctrl.step  = in_fire;
    ctrl.shift = emit_fire;
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      par_cnt   <= CW'(RESET_P);
      build_cnt <= CW'(RESET_P);
      emit_cnt  <= '0;
      root      <= rsenc_pkg::SYM_W'(1);
    end else if (cfg_wen) begin
      par_cnt   <= CW'(cfg_clamped);
      build_cnt <= CW'(cfg_clamped);
      emit_cnt  <= '0;
      root      <= rsenc_pkg::SYM_W'(1);
    end else begin
      if (building) begin
        build_cnt <= build_cnt - CW'(1);
        root      <= rsenc_pkg::gf_xtime(root);
      end
      if (in_fire && s_tlast) begin
        emit_cnt <= par_cnt;
      end else if (emit_fire) begin
        emit_cnt <= emit_cnt - CW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire || emit_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_tdata <= s_tdata;
      m_tuser <= 1'b0;
      m_tlast <= 1'b0;
    end else if (emit_fire) begin
      m_tdata <= rem_chain[0];
      m_tuser <= 1'b1;
      m_tlast <= (emit_cnt == CW'(1));
    end
  end

  // cell chain
  assign rem_chain[MAX_PARITY] = '0;
  assign coef_chain[0]         = rsenc_pkg::SYM_W'(1);

  for (genvar k = 0; k < MAX_PARITY; k++) begin : g_cell
    rsenc_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .fb       (fb),
      .root     (root),
      .rem_in   (rem_chain[k+1]),
      .coef_in  (coef_chain[k]),
      .rem_out  (rem_chain[k]),
      .coef_out (coef_chain[k+1])
    );
  end

  a_emit_load: assert property (@(posedge clk) disable iff (rst)
    in_fire && s_tlast |=> emit_cnt == $past(par_cnt))
    else $error("parity run length does not match parity count");

  a_no_emit_in_build: assert property (@(posedge clk) disable iff (rst)
    building |-> emit_cnt == '0)
    else $error("parity run during generator build");

  a_rem_cleared: assert property (@(posedge clk) disable iff (rst)
    emit_fire && emit_cnt == CW'(1) |=> rem_chain[0] == '0)
    else $error("remainder not cleared after parity run");

  a_tlast_parity: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser)
    else $error("end of codeword on a data item");

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the GF(256) systematic Reed-Solomon encoder
// ----------------------------------------------------------------------------
// Data items are sent with random gaps while the output side stalls at random.
// A local encoder model predicts the passed-through data and the parity run of
// every codeword. Each output item is compared field by field with the oldest
// prediction. The parity count is changed only while no output is pending.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAXP  = rsenc_pkg::MAX_PARITY_DEF;
  localparam int SYMW  = rsenc_pkg::SYM_W;
  localparam int CFGW  = rsenc_pkg::CFG_W;

  typedef struct packed {
    logic [SYMW-1:0] code_byte;
    logic            is_parity;
    logic            end_cw;
  } code_item_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_wen = 1'b0;
  logic [CFGW-1:0] cfg_wdata = '0;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [SYMW-1:0] s_tdata = '0;
  logic            s_tlast = 1'b0;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [SYMW-1:0] m_tdata;
  logic            m_tuser;
  logic            m_tlast;

  code_item_t      expected_code[$];
  int              mismatch_count = 0;
  int              send_idle_pct = 32;
  int              recv_idle_pct = 55;

  // encoder model state
  logic [SYMW-1:0] remainder_q [MAXP];
  logic [SYMW-1:0] gen_coef [MAXP+1];
  int unsigned     parity_cnt;

  rs_systematic_encoder_gf256 dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [SYMW-1:0] gf_times(input logic [SYMW-1:0] a,
                                               input logic [SYMW-1:0] b);
    logic [8:0]      x;
    logic [SYMW-1:0] r;
    x = {1'b0, a};
    r = '0;
    for (int k = 0; k < SYMW; k++) begin
      if (b[k]) begin
        r = r ^ x[7:0];
      end
      x = x << 1;
      if (x[8]) begin
        x = x ^ 9'h11d;
      end
    end
    return r;
  endfunction

  // clamp the written count and rebuild the product of (x + alpha^i)
  function automatic void load_parity_count(input logic [CFGW-1:0] value);
    logic [SYMW-1:0] root;
    parity_cnt = (value == 0) ? 1 : ((value > MAXP) ? MAXP : value);
    foreach (gen_coef[j]) gen_coef[j] = '0;
    foreach (remainder_q[j]) remainder_q[j] = '0;
    gen_coef[0] = 8'h01;
    root = 8'h01;
    for (int i = 0; i < parity_cnt; i++) begin
      for (int j = i + 1; j >= 1; j--) begin
        gen_coef[j] = gen_coef[j] ^ gf_times(gen_coef[j-1], root);
      end
      root = gf_times(root, 8'h02);
    end
  endfunction

  function automatic void encode_symbol(input logic [SYMW-1:0] d, input logic last_in);
    logic [SYMW-1:0] fb;
    code_item_t      entry;
    fb = d ^ remainder_q[0];
    for (int k = 0; k + 1 < parity_cnt; k++) begin
      remainder_q[k] = remainder_q[k+1] ^ gf_times(gen_coef[k+1], fb);
    end
    remainder_q[parity_cnt-1] = gf_times(gen_coef[parity_cnt], fb);
    entry = '{d, 1'b0, 1'b0};
    expected_code.insert(expected_code.size(), entry);
    if (last_in) begin
      for (int k = 0; k < parity_cnt; k++) begin
        entry = '{remainder_q[k], 1'b1, k + 1 == parity_cnt};
        expected_code.insert(expected_code.size(), entry);
      end
      foreach (remainder_q[j]) remainder_q[j] = '0;
    end
  endfunction

  // output side
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    code_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_code.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected item: byte %02h parity %0b end %0b",
                 $time, m_tdata, m_tuser, m_tlast);
      end else begin
        want = expected_code.pop_front();
        if (m_tdata !== want.code_byte) begin
          mismatch_count++;
          $display("%0t: code_byte expected %02h actual %02h",
                   $time, want.code_byte, m_tdata);
        end
        if (m_tuser !== want.is_parity) begin
          mismatch_count++;
          $display("%0t: is_parity expected %0b actual %0b",
                   $time, want.is_parity, m_tuser);
        end
        if (m_tlast !== want.end_cw) begin
          mismatch_count++;
          $display("%0t: end_of_codeword expected %0b actual %0b",
                   $time, want.end_cw, m_tlast);
        end
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic [SYMW-1:0] d, input logic last_in);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= last_in;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    encode_symbol(d, last_in);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    while (expected_code.size() != 0) @(negedge clk);
  endtask

  task automatic write_parity_count(input logic [CFGW-1:0] value);
    wait_for_drain();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    load_parity_count(value);
  endtask

  function automatic logic [SYMW-1:0] random_symbol();
    int pick;
    pick = $urandom_range(7);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hff;
    return SYMW'($urandom_range(255));
  endfunction

  task automatic send_codeword(input int len, input bit closed);
    for (int i = 0; i < len; i++) begin
      send_item(random_symbol(), closed && (i == len - 1));
    end
  endtask

  task automatic test_default_parity_count();
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h01, 1'b1);
    // all-zero message gives all-zero parity
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_parity_count_extremes();
    write_parity_count(6'd1);
    send_item(8'hff, 1'b0);
    send_item(8'h5a, 1'b1);
    write_parity_count(6'd32);
    send_item(8'hff, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'haa, 1'b1);
    // zero count behaves as one
    write_parity_count(6'd0);
    send_item(8'h37, 1'b1);
    // counts above the maximum saturate
    write_parity_count(6'd63);
    send_item(8'hff, 1'b1);
    write_parity_count(6'd33);
    send_item(8'h01, 1'b1);
  endtask

  task automatic test_single_symbol_codeword();
    write_parity_count(6'd7);
    send_item(8'hc3, 1'b1);
  endtask

  task automatic test_abandoned_codeword();
    write_parity_count(6'd20);
    send_item(8'h11, 1'b0);
    send_item(8'hee, 1'b0);
    send_item(8'h42, 1'b0);
    // rewrite mid-codeword clears the remainder
    write_parity_count(6'd20);
    send_item(8'h99, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_random_codewords(input int item_goal, input int snd_pct,
                                       input int rcv_pct);
    int          sent;
    int          pick;
    int          len;
    logic [CFGW-1:0] count;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    sent = 0;
    while (sent < item_goal) begin
      pick = $urandom_range(15);
      case (pick)
        0: count = 6'd0;
        1: count = CFGW'($urandom_range(33, 63));
        2: count = 6'd32;
        3: count = 6'd1;
        default: count = CFGW'($urandom_range(1, 32));
      endcase
      write_parity_count(count);
      repeat ($urandom_range(1, 4)) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        send_codeword(len, 1'b1);
        sent += len;
      end
      // partial codeword left open for the next count write
      if ($urandom_range(5) == 0) begin
        len = $urandom_range(1, 8);
        send_codeword(len, 1'b0);
        sent += len;
      end
    end
  endtask

  initial begin
    load_parity_count(CFGW'(rsenc_pkg::PARITY_RESET));
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_default_parity_count();
    test_parity_count_extremes();
    test_single_symbol_codeword();
    test_abandoned_codeword();
    test_random_codewords(105, 32, 55);
    test_random_codewords(105, 55, 32);
    test_random_codewords(105, 0, 0);

    wait_for_drain();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && expected_code.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
